// File: design/bme_pkg.sv
// Shared constants, types and state codes for the binary mask border erosion block.
`timescale 1ns / 1ps

package bme_pkg;

  // Mask geometry
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_W    = 64;
  localparam int ADDR_W   = $clog2(MAX_ROWS);
  localparam int CNT_W    = $clog2(MAX_ROWS + 1);
  localparam int DIST_W   = 6;
  localparam int MWID_W   = 7;
  localparam int AMT_W    = 7;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_BORDER_DISTANCE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH       = 1'd1;

  localparam logic [DIST_W-1:0] BORDER_DISTANCE_RESET = 6'd14;
  localparam logic [MWID_W-1:0] MAP_WIDTH_RESET       = 7'd64;

  // Main sequencer states
  typedef enum logic [2:0] {
    S_LOAD,
    S_PLAN,
    S_PASS,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_WAIT
  } state_t;

  // Position in the sequence of pass amounts
  typedef enum logic [1:0] {
    ST_FIRST,
    ST_LOOP,
    ST_REM,
    ST_DONE
  } stage_t;

  // Shift amount and neighbor validity for one row of a pass
  typedef struct packed {
    logic [ADDR_W-1:0] amt;
    logic              up_ok;
    logic              dn_ok;
  } shift_ctl_t;

endpackage

// File: design/bme_stream_if.sv
// Valid/ready channel interfaces for mask rows in and eroded rows out.
`timescale 1ns / 1ps

interface bme_in_if;
  logic                     valid;
  logic                     ready;
  logic [bme_pkg::ROW_W-1:0] row_bits;
  logic                     last_row;

  modport source (output valid, output row_bits, output last_row, input ready);
  modport sink   (input valid, input row_bits, input last_row, output ready);
endinterface

interface bme_out_if;
  logic                     valid;
  logic                     ready;
  logic [bme_pkg::ROW_W-1:0] eroded_row;
  logic                     last_out;

  modport source (output valid, output eroded_row, output last_out, input ready);
  modport sink   (input valid, input eroded_row, input last_out, output ready);
endinterface

// File: design/bme_row_shrink.sv
// One row of an erosion pass: AND of the row with its four neighbors at a distance.
`timescale 1ns / 1ps

module bme_row_shrink (
  input  logic [bme_pkg::ROW_W-1:0] center,
  input  logic [bme_pkg::ROW_W-1:0] up,
  input  logic [bme_pkg::ROW_W-1:0] dn,
  input  bme_pkg::shift_ctl_t       ctl,
  input  logic [bme_pkg::ROW_W-1:0] col_mask,
  output logic [bme_pkg::ROW_W-1:0] result
);
  import bme_pkg::*;

  logic [ROW_W-1:0] right_term;
  logic [ROW_W-1:0] left_term;
  logic [ROW_W-1:0] low_fill;
  logic [ROW_W-1:0] up_term;
  logic [ROW_W-1:0] dn_term;

  // Horizontal terms: the right neighbor falls off as 0, the left one counts as 1.
  assign right_term = center >> ctl.amt;
  assign low_fill   = (ROW_W'(1) << ctl.amt) - ROW_W'(1);
  assign left_term  = (center << ctl.amt) | low_fill;

  // Vertical terms count as 1 when the neighbor row lies outside the mask.
  assign up_term = ctl.up_ok ? up : '1;
  assign dn_term = ctl.dn_ok ? dn : '1;

  assign result = right_term & left_term & up_term & dn_term & col_mask;

endmodule

// File: design/binary_mask_border_erosion.sv
// Top level of the binary mask border erosion block.
`timescale 1ns / 1ps

// Rows of a mask arrive one word per cycle and are stored in one of two 64-row
// banks; the word flagged last_row closes the mask. The mask is then eroded by
// the pass amounts 1, 1, 2, 4, ... and a remainder that add up to
// border_distance, ping-ponging between the banks. In each pass the center,
// upper and lower neighbor rows of each stored row come through the single
// read port of the source bank one after another; an amount at or above the
// map width ends the passes at once with an empty mask. The eroded rows are
// then sent in order, each held until the output takes it, the last one with
// last_out set. A mask takes at most 7 passes, and no new row is accepted
// until the last eroded row has been taken. Configuration is sampled when
// the last row is accepted.
module binary_mask_border_erosion (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bme_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bme_pkg::CFG_DATA_W-1:0]   cfg_data,
  bme_in_if.sink                           in_row,
  bme_out_if.source                        out_row
);
  import bme_pkg::*;

  // Configuration registers
  logic [DIST_W-1:0] border_distance;
  logic [MWID_W-1:0] map_width;

  // Control state
  state_t            state, state_next;
  stage_t            stage;
  logic [CNT_W-1:0]  rows_loaded;
  logic [CNT_W-1:0]  rows_h;
  logic [AMT_W-1:0]  shrink_total;
  logic [AMT_W-1:0]  step;
  logic [DIST_W-1:0] distance;
  logic [MWID_W-1:0] width;
  logic [ROW_W-1:0]  col_mask;
  logic              empty;
  logic              cur;
  logic [ADDR_W-1:0] row;
  logic [1:0]        phase;
  logic [ADDR_W-1:0] amt;

  // Datapath registers
  logic [ROW_W-1:0]  center_q;
  logic [ROW_W-1:0]  up_q;
  logic [ROW_W-1:0]  out_data;
  logic              out_last;
  logic              out_valid;

  // Memories
  logic [ROW_W-1:0]  bank_a [MAX_ROWS];
  logic [ROW_W-1:0]  bank_b [MAX_ROWS];
  logic [ROW_W-1:0]  rdata_a, rdata_b;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic              wr_bank;
  logic [ADDR_W-1:0] wr_addr;
  logic [ROW_W-1:0]  wr_data;

  // Derived signals
  logic              in_acc;
  logic              row_stored;
  logic [ROW_W-1:0]  rd_masked;
  logic [ROW_W-1:0]  shrunk;
  shift_ctl_t        ctl;
  logic              last_row_of_map;
  logic [MWID_W-1:0] width_sat;
  logic [ROW_W-1:0]  mask_new;

  // Pass planning
  logic              plan_pass;
  logic              plan_output;
  logic [AMT_W-1:0]  plan_amt;
  stage_t            plan_stage;
  logic              plan_add;
  logic [AMT_W:0]    sum_check;

  assign in_acc     = in_row.valid && in_row.ready;
  assign row_stored = rows_loaded < CNT_W'(MAX_ROWS);

  // Width used by the erosion, saturated at the column count, and its mask.
  assign width_sat = (map_width > MWID_W'(MAX_COLS)) ? MWID_W'(MAX_COLS) : map_width;
  assign mask_new  = (width_sat >= MWID_W'(ROW_W)) ? '1
                   : ((ROW_W'(1) << width_sat[ADDR_W-1:0]) - ROW_W'(1));

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      border_distance <= BORDER_DISTANCE_RESET;
      map_width       <= MAP_WIDTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BORDER_DISTANCE: border_distance <= cfg_data[DIST_W-1:0];
        REG_MAP_WIDTH:       map_width       <= cfg_data[MWID_W-1:0];
        default: ;
      endcase
    end
  end

  // Bank memories, one write and one registered read per cycle each.
  always_ff @(posedge clk) begin
    if (wr_en && !wr_bank) bank_a[wr_addr] <= wr_data;
    if (wr_en && wr_bank)  bank_b[wr_addr] <= wr_data;
    rdata_a <= bank_a[rd_addr];
    rdata_b <= bank_b[rd_addr];
  end

  // Reads always come from the current bank; columns past the width read as 0.
  assign rd_masked = (cur ? rdata_b : rdata_a) & col_mask;

  // Neighbor validity for the row in work.
  assign ctl.amt   = amt;
  assign ctl.up_ok = ({1'b0, row} + CNT_W'(amt)) < rows_h;
  assign ctl.dn_ok = row >= amt;

  assign last_row_of_map = ({1'b0, row} + CNT_W'(1)) == rows_h;

  bme_row_shrink u_shrink (
    .center   (center_q),
    .up       (up_q),
    .dn       (rd_masked),
    .ctl      (ctl),
    .col_mask (col_mask),
    .result   (shrunk)
  );

  // Choose the next pass amount from the stage of the sequence.
  assign sum_check = {1'b0, shrink_total} + {1'b0, step};

  always_comb begin
    plan_pass   = 1'b0;
    plan_output = 1'b0;
    plan_amt    = '0;
    plan_stage  = stage;
    plan_add    = 1'b0;
    case (stage)
      ST_FIRST: begin
        plan_stage = ST_LOOP;
        if (distance != '0) begin
          plan_pass = 1'b1;
          plan_amt  = AMT_W'(1);
        end
      end
      ST_LOOP: begin
        if (sum_check <= (AMT_W + 1)'(distance)) begin
          plan_pass = 1'b1;
          plan_amt  = step;
          plan_add  = 1'b1;
        end else begin
          plan_stage = ST_REM;
        end
      end
      ST_REM: begin
        plan_stage = ST_DONE;
        if (shrink_total < AMT_W'(distance)) begin
          plan_pass = 1'b1;
          plan_amt  = AMT_W'(distance) - shrink_total;
        end
      end
      default: plan_output = 1'b1;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD:
        if (in_acc && in_row.last_row) state_next = S_PLAN;
      S_PLAN:
        if (plan_output || (plan_pass && (plan_amt >= AMT_W'(width)))) state_next = S_OUT_RD;
        else if (plan_pass) state_next = S_PASS;
      S_PASS:
        if ((phase == 2'd3) && last_row_of_map) state_next = S_PLAN;
      S_OUT_RD:
        state_next = S_OUT_LD;
      S_OUT_LD:
        state_next = S_OUT_WAIT;
      S_OUT_WAIT:
        if (out_row.ready) state_next = out_last ? S_LOAD : S_OUT_RD;
      default:
        state_next = S_LOAD;
    endcase
  end

  // Handshake and memory controls.
  always_comb begin
    in_row.ready = 1'b0;
    wr_en        = 1'b0;
    wr_bank      = cur;
    wr_addr      = row;
    wr_data      = shrunk;
    rd_addr      = row;
    unique case (state)
      S_LOAD: begin
        in_row.ready = 1'b1;
        wr_en        = in_acc && row_stored;
        wr_addr      = rows_loaded[ADDR_W-1:0];
        wr_data      = in_row.row_bits;
      end
      S_PASS: begin
        case (phase)
          2'd1:    rd_addr = row + amt;
          2'd2:    rd_addr = row - amt;
          2'd3: begin
            wr_en   = 1'b1;
            wr_bank = !cur;
          end
          default: rd_addr = row;
        endcase
      end
      default: ;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      rows_loaded  <= '0;
      shrink_total <= '0;
      cur          <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (row_stored) rows_loaded <= rows_loaded + CNT_W'(1);
            if (in_row.last_row) begin
              shrink_total <= AMT_W'(1);
            end
          end
        end
        S_PLAN: begin
          if (plan_add) shrink_total <= shrink_total + step;
        end
        S_PASS: begin
          if ((phase == 2'd3) && last_row_of_map) cur <= !cur;
        end
        S_OUT_LD: out_valid <= 1'b1;
        S_OUT_WAIT: begin
          if (out_row.ready) begin
            out_valid <= 1'b0;
            if (out_last) rows_loaded <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Per-mask working registers and the output word.
  always_ff @(posedge clk) begin
    unique case (state)
      S_LOAD: begin
        if (in_acc && in_row.last_row) begin
          rows_h   <= rows_loaded + CNT_W'(row_stored);
          distance <= border_distance;
          width    <= width_sat;
          col_mask <= mask_new;
          empty    <= 1'b0;
          stage    <= ST_FIRST;
          step     <= AMT_W'(1);
        end
      end
      S_PLAN: begin
        stage <= plan_stage;
        row   <= '0;
        phase <= 2'd0;
        amt   <= plan_amt[ADDR_W-1:0];
        if (plan_add) step <= step << 1;
        if (plan_pass && (plan_amt >= AMT_W'(width))) empty <= 1'b1;
      end
      S_PASS: begin
        phase <= phase + 2'd1;
        if (phase == 2'd1) center_q <= rd_masked;
        if (phase == 2'd2) up_q     <= rd_masked;
        if ((phase == 2'd3) && !last_row_of_map) row <= row + ADDR_W'(1);
      end
      S_OUT_LD: begin
        out_data <= empty ? '0 : rd_masked;
        out_last <= last_row_of_map;
      end
      S_OUT_WAIT: begin
        if (out_row.ready && !out_last) row <= row + ADDR_W'(1);
      end
      default: ;
    endcase
  end

  assign out_row.valid      = out_valid;
  assign out_row.eroded_row = out_data;
  assign out_row.last_out   = out_last;

  // No new row is taken while an eroded word is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    in_row.ready |-> !out_row.valid)
    else $error("input ready while an output word is pending");

  // The stored row count never passes the bank depth.
  a_rows_bound: assert property (@(posedge clk) disable iff (rst)
    rows_loaded <= CNT_W'(MAX_ROWS))
    else $error("row count beyond bank depth");

  // Closing a mask stops the input side at once.
  a_close_stops: assert property (@(posedge clk) disable iff (rst)
    (in_row.valid && in_row.ready && in_row.last_row) |=> !in_row.ready)
    else $error("input still ready after the last row");

  // Delivering the final eroded word reopens the input side.
  a_final_reopens: assert property (@(posedge clk) disable iff (rst)
    (out_row.valid && out_row.ready && out_row.last_out) |=>
      (in_row.ready && rows_loaded == '0))
    else $error("input not reopened after the final eroded word");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the binary mask border erosion block.
`timescale 1ns / 1ps

module tb_top;
  import bme_pkg::*;

  typedef struct {
    logic [ROW_W-1:0] row_bits;
    logic             last_row;
  } row_item_t;

  typedef struct {
    logic [ROW_W-1:0] eroded_row;
    logic             last_out;
  } eroded_item_t;

  typedef enum int {SHAPE_NOISE, SHAPE_RECT, SHAPE_HOLES} shape_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  bme_in_if  in_if ();
  bme_out_if out_if ();

  binary_mask_border_erosion dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_row    (in_if),
    .out_row   (out_if)
  );

  // Erosion model state, mirroring the block's settings and row store.
  int unsigned      model_distance = BORDER_DISTANCE_RESET;
  int unsigned      model_width    = MAP_WIDTH_RESET;
  logic [ROW_W-1:0] model_rows [MAX_ROWS];
  int unsigned      model_count    = 0;

  row_item_t    pending_rows [$];
  eroded_item_t expected_rows [$];
  int unsigned  fail_count  = 0;
  int unsigned  random_rows = 0;

  // Sender and receiver pacing.
  int unsigned burst_left  = 1;
  int unsigned gap_left    = 0;
  int unsigned stall_timer = 0;
  int unsigned stall_pct   = 0;

  always #1 clk = ~clk;

  // Columns in use for a given width.
  function automatic logic [ROW_W-1:0] col_mask(int unsigned w);
    if (w >= ROW_W) return '1;
    return (64'd1 << w) - 64'd1;
  endfunction

  // One erosion pass by amount a over the first h stored rows.
  task automatic shrink_rows(int unsigned h, int unsigned w, int unsigned a);
    logic [ROW_W-1:0] scratch [MAX_ROWS];
    logic [ROW_W-1:0] v;
    if (a >= w) begin
      for (int y = 0; y < h; y++) model_rows[y] = '0;
    end else begin
      for (int y = 0; y < h; y++) begin
        v = model_rows[y] >> a;
        v &= (model_rows[y] << a) | ((64'd1 << a) - 64'd1);
        if (y + a < h) v &= model_rows[y + a];
        if (y >= a) v &= model_rows[y - a];
        scratch[y] = v & col_mask(w);
      end
      for (int y = 0; y < h; y++) model_rows[y] = scratch[y];
    end
  endtask

  // Store each accepted row; the last one runs the erosion and queues the results.
  always @(posedge clk) begin : row_model
    int unsigned  h, w, total, amount;
    eroded_item_t word;
    if (!rst && in_if.valid && in_if.ready) begin
      if (model_count < MAX_ROWS) begin
        model_rows[model_count] = in_if.row_bits;
        model_count++;
      end
      if (in_if.last_row) begin
        h = model_count;
        w = (model_width > MAX_COLS) ? MAX_COLS : model_width;
        for (int y = 0; y < h; y++) model_rows[y] &= col_mask(w);
        total = 1;
        if (model_distance >= 1) shrink_rows(h, w, 1);
        for (amount = 1; total + amount <= model_distance; amount *= 2) begin
          shrink_rows(h, w, amount);
          total += amount;
        end
        if (total < model_distance) shrink_rows(h, w, model_distance - total);
        for (int y = 0; y < h; y++) begin
          word.eroded_row = model_rows[y] & col_mask(w);
          word.last_out   = (y + 1 == h);
          expected_rows.push_back(word);
        end
        model_count = 0;
      end
    end
  end

  // Row driver: bursts of words with random gaps between them.
  always @(posedge clk) begin : row_driver
    row_item_t item;
    if (rst) begin
      in_if.valid    <= 1'b0;
      in_if.row_bits <= '0;
      in_if.last_row <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (pending_rows.size() > 0) begin
        item = pending_rows.pop_front();
        in_if.valid    <= 1'b1;
        in_if.row_bits <= item.row_bits;
        in_if.last_row <= item.last_row;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: the stall rate is redrawn whenever a random timer runs out, zero included.
  always @(posedge clk) begin : eroded_sink
    if (rst) begin
      out_if.ready <= 1'b0;
    end else begin
      if (stall_timer == 0) begin
        stall_timer = $urandom_range(50, 400);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 30;
          2: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end else begin
        stall_timer--;
      end
      out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Compare every accepted eroded word with the oldest prediction.
  always @(posedge clk) begin : eroded_check
    eroded_item_t want;
    if (!rst && out_if.valid && out_if.ready) begin
      if (expected_rows.size() == 0) begin
        $error("eroded word with no prediction: eroded_row %h last_out %b",
               out_if.eroded_row, out_if.last_out);
        fail_count++;
      end else begin
        want = expected_rows.pop_front();
        if (out_if.eroded_row !== want.eroded_row) begin
          $error("eroded_row mismatch: expected %h, actual %h",
                 want.eroded_row, out_if.eroded_row);
          fail_count++;
        end
        if (out_if.last_out !== want.last_out) begin
          $error("last_out mismatch: expected %b, actual %b", want.last_out, out_if.last_out);
          fail_count++;
        end
      end
    end
  end

  // Wait until every row is sent and every prediction is met, then let the block finish.
  task automatic settle();
    @(negedge clk);
    while (pending_rows.size() != 0 || in_if.valid || expected_rows.size() != 0)
      @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Write both registers while the block is idle.
  task automatic set_config(logic [CFG_DATA_W-1:0] distance, logic [CFG_DATA_W-1:0] width);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BORDER_DISTANCE;
    cfg_data  <= distance;
    @(posedge clk);
    cfg_index <= REG_MAP_WIDTH;
    cfg_data  <= width;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_distance = distance[DIST_W-1:0];
    model_width    = width;
    @(negedge clk);
  endtask

  task automatic add_row(logic [ROW_W-1:0] bits, logic last);
    row_item_t item;
    item.row_bits = bits;
    item.last_row = last;
    pending_rows.push_back(item);
  endtask

  // A mask of h rows: pure noise, a solid rectangle, or a rectangle with holes.
  task automatic add_random_mask(int unsigned h);
    int unsigned      r, x0, span, y0, y1;
    shape_t           shape;
    logic [ROW_W-1:0] rect, bits, holes;
    r     = $urandom_range(0, 3);
    shape = (r == 0) ? SHAPE_NOISE : (r == 1) ? SHAPE_RECT : SHAPE_HOLES;
    x0    = $urandom_range(0, 16);
    span  = $urandom_range(1, ROW_W - x0);
    rect  = (span >= ROW_W) ? '1 : (((64'd1 << span) - 64'd1) << x0);
    y0    = $urandom_range(0, h / 4);
    y1    = $urandom_range(y0, h - 1);
    for (int y = 0; y < h; y++) begin
      case (shape)
        SHAPE_NOISE: bits = {$urandom, $urandom};
        SHAPE_RECT:  bits = (y >= y0 && y <= y1) ? rect : '0;
        default: begin
          holes = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
          bits  = (y >= y0 && y <= y1) ? rect : ({$urandom, $urandom} & {$urandom, $urandom});
          bits &= ~holes;
        end
      endcase
      // Occasional stray row breaks up the shape.
      if ($urandom_range(0, 19) == 0) bits = {$urandom, $urandom};
      add_row(bits, y == h - 1);
    end
  endtask

  initial begin
    int unsigned           h, mask_no, r;
    logic [CFG_DATA_W-1:0] d, w;
    in_if.valid    = 1'b0;
    in_if.row_bits = '0;
    in_if.last_row = 1'b0;
    out_if.ready   = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings on a solid block of four rows.
    for (int y = 0; y < 4; y++) add_row('1, y == 3);
    settle();

    // Zero distance passes the mask through unchanged.
    set_config(7'd0, 7'd64);
    add_row('1, 1'b0);
    add_row('0, 1'b1);
    settle();

    // An amount at least as large as the width empties the map.
    set_config(7'd63, 7'd1);
    add_row('1, 1'b1);
    settle();

    // Width zero gives all-zero rows.
    set_config(7'd5, 7'd0);
    add_row({$urandom, $urandom}, 1'b1);
    settle();

    // A width above the maximum is clipped to the full row.
    set_config(7'd1, 7'd127);
    add_row({32{2'b10}}, 1'b0);
    add_row({32{2'b01}}, 1'b0);
    add_row('1, 1'b1);
    settle();

    // Row bits beyond the width are ignored.
    set_config(7'd5, 7'd40);
    add_row('1, 1'b0);
    add_row('1, 1'b1);
    settle();

    // Amounts taller than the mask apply no vertical terms.
    set_config(7'd20, 7'd64);
    add_row('1, 1'b0);
    add_row('1, 1'b1);
    settle();

    // Single-step erosion of a striped pair.
    set_config(7'd1, 7'd64);
    add_row({16'h0000, 16'hffff, 16'h0000, 16'hffff}, 1'b0);
    add_row({16'hffff, 16'h0000, 16'hffff, 16'h0000}, 1'b1);
    settle();

    // Random phases: new settings, then a few masks, mostly short ones.
    mask_no = 0;
    while (random_rows < 320) begin
      settle();
      r = $urandom_range(0, 7);
      case (r)
        0: d = 7'd0;
        1: d = 7'd63;
        2: d = 7'd1;
        3: d = 7'h40 | 7'($urandom_range(0, 63));
        default: d = 7'($urandom_range(2, 12));
      endcase
      r = $urandom_range(0, 9);
      case (r)
        0: w = 7'd0;
        1: w = 7'd1;
        2: w = 7'd64;
        3: w = 7'($urandom_range(65, 127));
        4: w = 7'd63;
        default: w = 7'($urandom_range(12, 64));
      endcase
      set_config(d, w);
      repeat ($urandom_range(1, 4)) begin
        // Make sure one mask overflows the store and one fills it exactly.
        if (mask_no == 1) begin
          h = 66;
        end else if (mask_no == 4) begin
          h = MAX_ROWS;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 70) h = $urandom_range(1, 8);
          else if (r < 92) h = $urandom_range(9, 20);
          else if (r < 97) h = $urandom_range(21, 64);
          else h = $urandom_range(65, 72);
        end
        add_random_mask(h);
        random_rows += (h > MAX_ROWS) ? MAX_ROWS : h;
        mask_no++;
      end
    end

    settle();
    repeat (30) @(negedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard limit on the run time.
  initial begin
    #1000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
